// ----- rtl/sample_unpacker_32_to_14_defines.svh -----
// ----------------------------------------------------------------------------
// sample_unpacker_32_to_14_defines.svh
// Assertion macros used by the sample unpacker back end (sunp_back).
// ----------------------------------------------------------------------------
`ifndef SAMPLE_UNPACKER_32_TO_14_DEFINES_SVH
`define SAMPLE_UNPACKER_32_TO_14_DEFINES_SVH

// Condition that holds at every clock edge out of reset
`define SUNP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication
`define SUNP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SUNP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sunp_pkg.sv -----
// ----------------------------------------------------------------------------
// sunp_pkg
// Fixed widths, queue sizing and the per-word control struct.
// ----------------------------------------------------------------------------
package sunp_pkg;

    // Fixed field widths
    localparam int WORD_W       = 32;
    localparam int SAMPLE_W     = 14;
    localparam int IDX_W        = 7;
    localparam int MAX_PER_WORD = 3;

    // Word queue between front and back
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // Per-word control: samples to emit (1..3) and end of block on the last one
    typedef struct packed {
        logic [1:0] count;
        logic       eob;
    } word_ctrl_t;

endpackage

// ----- rtl/sunp_front.sv -----
// ----------------------------------------------------------------------------
// sunp_front
// Accepts packed words, merges them with the leftover bits and works out
// how many samples each word yields; tracks leftover and block position.
// ----------------------------------------------------------------------------
module sunp_front #(
    parameter int SAMPLE_BITS   = 14,
    parameter int BLOCK_SAMPLES = 128
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [sunp_pkg::WORD_W-1:0]          word,
    input  logic                                 word_valid,
    output logic                                 word_ready,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output logic [SAMPLE_BITS+sunp_pkg::WORD_W-2:0] push_acc,
    output logic [$clog2(BLOCK_SAMPLES)-1:0]     push_start,
    output sunp_pkg::word_ctrl_t                 push_ctrl
);
    import sunp_pkg::*;

    localparam int LW    = SAMPLE_BITS - 1;
    localparam int ACC_W = LW + WORD_W;
    localparam int AVW   = $clog2(ACC_W + 1);
    localparam int CNTW  = $clog2(SAMPLE_BITS);
    localparam int CW    = $clog2(BLOCK_SAMPLES);

    localparam logic [AVW-1:0] ONE_SB   = AVW'(SAMPLE_BITS);
    localparam logic [AVW-1:0] TWO_SB   = AVW'(2 * SAMPLE_BITS);
    localparam logic [AVW-1:0] THREE_SB = AVW'(3 * SAMPLE_BITS);
    localparam logic [AVW-1:0] LW_AV    = AVW'(LW);
    localparam logic [CW-1:0]  LAST_IDX = CW'(BLOCK_SAMPLES - 1);

    logic [LW-1:0]    lo_bits_reg, lo_bits_next;
    logic [CNTW-1:0]  lo_cnt_reg, lo_cnt_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    logic [ACC_W-1:0] acc;
    logic [AVW-1:0]   avail;
    logic [1:0]       n_fit;
    logic [CW-1:0]    rem;
    logic [CW-1:0]    rem_p1;
    logic             hits_end;
    logic [ACC_W-1:0] rest_acc;
    logic [AVW-1:0]   rest_avail;
    logic [CNTW-1:0]  rest_cnt;
    logic [LW-1:0]    rest_mask;
    logic             accept;

    // Join leftover with the new word, oldest bits lowest
    assign acc   = ACC_W'(lo_bits_reg) | (ACC_W'(word) << lo_cnt_reg);
    assign avail = AVW'(lo_cnt_reg) + AVW'(WORD_W);

    // Complete samples available, capped at three
    assign n_fit = (avail >= THREE_SB) ? 2'd3 :
                   (avail >= TWO_SB)   ? 2'd2 : 2'd1;

    // Does the block end inside this word
    assign rem      = LAST_IDX - cnt_reg;
    assign rem_p1   = rem + CW'(1);
    assign hits_end = (CW'(n_fit) > rem);

    // Bits left after the emitted samples
    always_comb
    begin
        case (n_fit)
            2'd3:
            begin
                rest_acc   = acc >> (3 * SAMPLE_BITS);
                rest_avail = avail - THREE_SB;
            end
            2'd2:
            begin
                rest_acc   = acc >> (2 * SAMPLE_BITS);
                rest_avail = avail - TWO_SB;
            end
            default:
            begin
                rest_acc   = acc >> SAMPLE_BITS;
                rest_avail = avail - ONE_SB;
            end
        endcase
    end

    // Leftover saturates at SAMPLE_BITS-1, keeping the oldest bits
    assign rest_cnt  = (rest_avail > LW_AV) ? CNTW'(LW) : rest_avail[CNTW-1:0];
    assign rest_mask = ~({LW{1'b1}} << rest_cnt);

    assign word_ready = push_ready;
    assign accept     = word_valid && word_ready;

    // Next state
    always_comb
    begin
        lo_bits_next = lo_bits_reg;
        lo_cnt_next  = lo_cnt_reg;
        cnt_next     = cnt_reg;
        if (accept)
        begin
            if (hits_end)
            begin
                lo_bits_next = '0;
                lo_cnt_next  = '0;
                cnt_next     = '0;
            end
            else
            begin
                lo_bits_next = rest_acc[LW-1:0] & rest_mask;
                lo_cnt_next  = rest_cnt;
                cnt_next     = cnt_reg + CW'(n_fit);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_bits_reg <= '0;
            lo_cnt_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            lo_bits_reg <= lo_bits_next;
            lo_cnt_reg  <= lo_cnt_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Queue entry for this word
    assign push_valid      = word_valid;
    assign push_acc        = acc;
    assign push_start      = cnt_reg;
    assign push_ctrl.count = hits_end ? rem_p1[1:0] : n_fit;
    assign push_ctrl.eob   = hits_end;

endmodule

// ----- rtl/sunp_fifo.sv -----
// ----------------------------------------------------------------------------
// sunp_fifo
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module sunp_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);
    import sunp_pkg::*;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QPTR_W:0]   FULL_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    logic [DATA_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push_fire;

    assign push_ready = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push_fire && !pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (!push_fire && pop)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/sunp_back.sv -----
// ----------------------------------------------------------------------------
// sunp_back
// Walks the queue's head word into the output register one sample per cycle
// while it is free or taken, tagging index, last-of-word and end-of-block.
// ----------------------------------------------------------------------------
`include "sample_unpacker_32_to_14_defines.svh"

module sunp_back #(
    parameter int SAMPLE_BITS   = 14,
    parameter int BLOCK_SAMPLES = 128
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    head_valid,
    input  logic [SAMPLE_BITS+sunp_pkg::WORD_W-2:0] head_acc,
    input  logic [$clog2(BLOCK_SAMPLES)-1:0]        head_start,
    input  sunp_pkg::word_ctrl_t                    head_ctrl,
    output logic                                    pop,
    output logic [sunp_pkg::SAMPLE_W-1:0]           sample,
    output logic [sunp_pkg::IDX_W-1:0]              sample_index,
    output logic                                    last_of_word,
    output logic                                    end_of_block,
    output logic                                    sample_valid,
    input  logic                                    sample_ready
);
    import sunp_pkg::*;

    localparam int ACC_W = SAMPLE_BITS - 1 + WORD_W;
    localparam int CW    = $clog2(BLOCK_SAMPLES);

    logic [1:0]                    k_reg, k_next;
    logic                          valid_reg, valid_next;
    logic [SAMPLE_W-1:0]           sample_reg;
    logic [IDX_W-1:0]              index_reg;
    logic                          last_reg;
    logic                          eob_reg;

    logic [ACC_W-1:0]              sel_acc;
    logic [SAMPLE_BITS+SAMPLE_W-1:0] sample_wide;
    logic [CW-1:0]                 idx_full;
    logic [CW+IDX_W-1:0]           idx_wide;
    logic                          is_last;
    logic                          load;

    // Select the k-th sample of the head word
    always_comb
    begin
        case (k_reg)
            2'd0:    sel_acc = head_acc;
            2'd1:    sel_acc = head_acc >> SAMPLE_BITS;
            default: sel_acc = head_acc >> (2 * SAMPLE_BITS);
        endcase
    end

    assign sample_wide = {{SAMPLE_W{1'b0}}, sel_acc[SAMPLE_BITS-1:0]};
    assign idx_full    = head_start + CW'(k_reg);
    assign idx_wide    = {{IDX_W{1'b0}}, idx_full};
    assign is_last     = (k_reg == (head_ctrl.count - 2'd1));

    // Load the output register when it is empty or being taken
    assign load = head_valid && (!valid_reg || sample_ready);
    assign pop  = load && is_last;

    always_comb
    begin
        k_next     = k_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            k_next     = is_last ? 2'd0 : k_reg + 2'd1;
        end
        else if (sample_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= sample_wide[SAMPLE_W-1:0];
            index_reg  <= idx_wide[IDX_W-1:0];
            last_reg   <= is_last;
            eob_reg    <= is_last && head_ctrl.eob;
        end
    end

    assign sample       = sample_reg;
    assign sample_index = index_reg;
    assign last_of_word = last_reg;
    assign end_of_block = eob_reg;
    assign sample_valid = valid_reg;

    // Checks
    `SUNP_ASSERT_IMPL(a_k_in_range, head_valid, k_reg < head_ctrl.count, "sample step past word")
    `SUNP_ASSERT_IMPL(a_eob_is_last, valid_reg && eob_reg, last_reg, "end of block not last of word")
    `SUNP_ASSERT_NEXT(a_pop_rewinds, pop, k_reg == 2'd0, "sample step not cleared after pop")

endmodule

// ----- rtl/sample_unpacker_32_to_14.sv -----
// A word's first sample goes through the queue write, then the output register load,
// which waits until the output register is free.
// Throughput: one sample per cycle from a single output register while sample_ready
// is high; a word yields 2 or 3 samples at the default sizes (16 samples per 7 words).
// Reset (rst_n, async, active low) clears leftover bits, block counter, queue and
// output valid; the block is ready to accept words as soon as reset is released.
// ----------------------------------------------------------------------------
// sample_unpacker_32_to_14
// Unpacks 14-bit samples, packed LSB first, from a stream of 32-bit words.
// ----------------------------------------------------------------------------
module sample_unpacker_32_to_14 #(
    parameter int SAMPLE_BITS   = 14,
    parameter int BLOCK_SAMPLES = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sunp_pkg::WORD_W-1:0]   word,
    input  logic                          word_valid,
    output logic                          word_ready,
    output logic [sunp_pkg::SAMPLE_W-1:0] sample,
    output logic [sunp_pkg::IDX_W-1:0]    sample_index,
    output logic                          last_of_word,
    output logic                          end_of_block,
    output logic                          sample_valid,
    input  logic                          sample_ready
);
    import sunp_pkg::*;

    localparam int ACC_W  = SAMPLE_BITS - 1 + WORD_W;
    localparam int CW     = $clog2(BLOCK_SAMPLES);
    localparam int CTRL_W = $bits(word_ctrl_t);
    localparam int DATA_W = ACC_W + CW + CTRL_W;

    logic              push_valid;
    logic              push_ready;
    logic [ACC_W-1:0]  push_acc;
    logic [CW-1:0]     push_start;
    word_ctrl_t        push_ctrl;
    logic              pop;
    logic              head_valid;
    logic [DATA_W-1:0] head_data;
    logic [ACC_W-1:0]  head_acc;
    logic [CW-1:0]     head_start;
    word_ctrl_t        head_ctrl;

    // Front: merge and classify
    sunp_front #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (word),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_acc   (push_acc),
        .push_start (push_start),
        .push_ctrl  (push_ctrl)
    );

    // Word queue
    sunp_fifo #(
        .DATA_W (DATA_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_acc, push_start, push_ctrl}),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign head_acc   = head_data[DATA_W-1 -: ACC_W];
    assign head_start = head_data[CTRL_W +: CW];
    assign head_ctrl  = head_data[CTRL_W-1:0];

    // Back: emit samples
    sunp_back #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_acc     (head_acc),
        .head_start   (head_start),
        .head_ctrl    (head_ctrl),
        .pop          (pop),
        .sample       (sample),
        .sample_index (sample_index),
        .last_of_word (last_of_word),
        .end_of_block (end_of_block),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready)
    );

endmodule
